// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/htd_pkg.sv -----
// ----------------------------------------------------------------------------
// htd_pkg
// types and constants shared by the huffman tree decoder modules
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int IDX_W         = 9;
  localparam int NODE_COUNT    = 2 ** IDX_W;
  localparam int SYM_W         = 8;
  localparam int BITS_PER_ITEM = 8;
  localparam int CNT_W         = 4;
  localparam int FUNC_W        = 2;
  localparam int QUEUE_DEPTH   = 4;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_DECODE  = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
  } node_t;

  typedef struct packed {
    func_e                    func;
    logic [IDX_W-1:0]         node_index;
    node_t                    node;
    logic [BITS_PER_ITEM-1:0] code_bits;
    logic [CNT_W-1:0]         bit_count;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ----- src/htd_queue.sv -----
// ----------------------------------------------------------------------------
// htd_queue
// small fifo of classified items between the front and the walk engine
// ----------------------------------------------------------------------------
module htd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  htd_pkg::item_t      push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output htd_pkg::queue_head_t head_o
);

  localparam int PTR_W = $clog2(htd_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(htd_pkg::QUEUE_DEPTH + 1);

  htd_pkg::item_t    slot_q [htd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o       = (fill_q == FILL_W'(htd_pkg::QUEUE_DEPTH));
  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- src/htd_front.sv -----
// ----------------------------------------------------------------------------
// htd_front
// accepts input words, unpacks and classifies them, drops no-op items
// ----------------------------------------------------------------------------
module htd_front (
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [htd_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic [htd_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output htd_pkg::item_t                  push_item_o
);

  logic [htd_pkg::CNT_W-1:0] raw_count;
  logic                      keep;

  assign s_axis_tready_o = !queue_full_i;

  assign raw_count = s_axis_tdata_i[47:44];

  always_comb begin
    push_item_o.func             = htd_pkg::func_e'(s_axis_tuser_i);
    push_item_o.node_index       = s_axis_tdata_i[8:0];
    push_item_o.node.leaf        = s_axis_tdata_i[9];
    push_item_o.node.symbol      = s_axis_tdata_i[17:10];
    push_item_o.node.left_child  = s_axis_tdata_i[26:18];
    push_item_o.node.right_child = s_axis_tdata_i[35:27];
    push_item_o.code_bits        = s_axis_tdata_i[43:36];
    push_item_o.bit_count        = raw_count;
    if (raw_count > htd_pkg::CNT_W'(htd_pkg::BITS_PER_ITEM)) begin
      push_item_o.bit_count = htd_pkg::CNT_W'(htd_pkg::BITS_PER_ITEM);
    end
    case (s_axis_tuser_i)
      htd_pkg::FUNC_WRITE:   keep = 1'b1;
      htd_pkg::FUNC_RESTART: keep = 1'b1;
      htd_pkg::FUNC_DECODE:  keep = (raw_count != '0);
      default:               keep = 1'b0;
    endcase
  end

  assign push_o = s_axis_tvalid_i && !queue_full_i && keep;

endmodule

// ----- src/htd_back.sv -----
// ----------------------------------------------------------------------------
// htd_back
// walk engine: node table, walk position, symbol hold and output register
// ----------------------------------------------------------------------------
module htd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wen_i,
  input  logic [htd_pkg::IDX_W-1:0]     cfg_wdata_i,
  input  htd_pkg::queue_head_t          head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [htd_pkg::SYM_W-1:0]     out_symbol_o,
  output logic                          out_last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_NXT,
    S_FLUSH
  } state_e;

  localparam int BW = htd_pkg::BITS_PER_ITEM;
  localparam int IW = htd_pkg::IDX_W;
  localparam int SW = htd_pkg::SYM_W;
  localparam int CW = htd_pkg::CNT_W;

  htd_pkg::node_t node_mem_q [htd_pkg::NODE_COUNT];
  htd_pkg::node_t rdata_q;

  state_e          state_q, state_d;
  logic [IW-1:0]   root_q, root_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [BW-1:0]   bits_q, bits_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pend_vld_q, pend_vld_d;
  logic [SW-1:0]   pend_sym_q, pend_sym_d;
  logic            out_vld_q, out_vld_d;
  logic [SW-1:0]   out_sym_q, out_sym_d;
  logic            out_last_q, out_last_d;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_raddr;
  logic            out_free, can_emit, emit, last_bit;
  logic [SW-1:0]   emit_sym;
  logic [BW-1:0]   bits_shift;
  logic [IW-1:0]   child;

  assign out_free   = !out_vld_q || out_ready_i;
  assign can_emit   = !pend_vld_q || out_free;
  assign bits_shift = bits_q << 1;
  assign last_bit   = (cnt_q == CW'(1));

  always_comb begin
    state_d    = state_q;
    root_d     = cfg_wen_i ? cfg_wdata_i : root_q;
    pos_d      = pos_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_sym_d = pend_sym_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_sym_d  = out_sym_q;
    out_last_d = out_last_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = pos_q;
    emit       = 1'b0;
    emit_sym   = rdata_q.symbol;
    child      = bits_q[BW-1] ? rdata_q.right_child : rdata_q.left_child;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.item.func)
            htd_pkg::FUNC_WRITE: begin
              mem_we = 1'b1;
            end
            htd_pkg::FUNC_RESTART: begin
              pos_d = root_q;
            end
            htd_pkg::FUNC_DECODE: begin
              bits_d  = head_i.item.code_bits;
              cnt_d   = head_i.item.bit_count;
              mem_re  = 1'b1;
              state_d = S_BIT;
            end
            default: begin
            end
          endcase
        end
      end

      // rdata holds the node at the walk position
      S_BIT: begin
        if (rdata_q.leaf) begin
          if (can_emit) begin
            emit   = 1'b1;
            pos_d  = root_q;
            bits_d = bits_shift;
            cnt_d  = cnt_q - CW'(1);
            if (last_bit) begin
              state_d = S_FLUSH;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = root_q;
            end
          end
        end else begin
          pos_d     = child;
          mem_re    = 1'b1;
          mem_raddr = child;
          state_d   = S_NXT;
        end
      end

      // rdata holds the child reached by the current bit
      S_NXT: begin
        if (rdata_q.leaf) begin
          if (can_emit) begin
            emit   = 1'b1;
            pos_d  = root_q;
            bits_d = bits_shift;
            cnt_d  = cnt_q - CW'(1);
            if (last_bit) begin
              state_d = S_FLUSH;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = root_q;
              state_d   = S_BIT;
            end
          end
        end else begin
          bits_d = bits_shift;
          cnt_d  = cnt_q - CW'(1);
          if (last_bit) begin
            state_d = S_FLUSH;
          end else begin
            child     = bits_shift[BW-1] ? rdata_q.right_child : rdata_q.left_child;
            pos_d     = child;
            mem_re    = 1'b1;
            mem_raddr = child;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_sym_d  = pend_sym_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new symbol pushes the held one out as a non-final word
    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_sym_d  = pend_sym_q;
        out_last_d = 1'b0;
      end
      pend_vld_d = 1'b1;
      pend_sym_d = emit_sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      root_q     <= '0;
      pos_q      <= '0;
      bits_q     <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      pend_sym_q <= '0;
      out_vld_q  <= 1'b0;
      out_sym_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      root_q     <= root_d;
      pos_q      <= pos_d;
      bits_q     <= bits_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      pend_sym_q <= pend_sym_d;
      out_vld_q  <= out_vld_d;
      out_sym_q  <= out_sym_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[head_i.item.node_index] <= head_i.item.node;
    end
    if (mem_re) begin
      rdata_q <= node_mem_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- src/huffman_tree_decoder.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// tree-walk decoder: node table writes, walk restart and code bit decoding
//
//   channel   dir  tdata                           tuser / tlast
//   s_axis    in   node and code fields, 48 bits   tuser: func
//   m_axis    out  symbol, 8 bits                  tlast: final symbol of item
//   cfg       in   root_index, 9 bits              write enable only
//
// node write and restart are handled in the idle state of the walk engine
// decode walks the tree bit by bit, one node table read per step
// a four-entry queue decouples input acceptance from the walk engine
// a full output register stalls the walk, a full queue drops tready
// reset clears control state only, the node table is undefined until written
// ----------------------------------------------------------------------------
module huffman_tree_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // node_index, node_leaf, node_symbol, left_child, right_child,
  // code_bits, bit_count
  input  logic [47:0] s_axis_tdata_i,
  // func
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // symbol
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic                 push, queue_full, pop;
  htd_pkg::item_t       push_item;
  htd_pkg::queue_head_t head;

  htd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  htd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  htd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_symbol_o (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ----- src/htd_checker.sv -----
// ----------------------------------------------------------------------------
// htd_checker
// port-level checks on the huffman tree decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_wen_i,
  input logic [8:0]  cfg_wdata_i,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic cfg_seen;
  assign cfg_seen = cfg_wen_i || (cfg_wdata_i != '0) || (s_axis_tdata_i != '0)
                    || (s_axis_tuser_i != '0);

  // stalled output word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output word changed under stall")
  // empty after reset
  `ASSERT_IMPL(a_reset_empty, clk_i, rst_ni, !$past(rst_ni), s_axis_tready_o && !m_axis_tvalid_o, "not empty after reset")
  // queue fills only through an accepted input word
  `ASSERT_IMPL(a_ready_fall, clk_i, rst_ni, $fell(s_axis_tready_o), $past(s_axis_tvalid_i && s_axis_tready_o), "ready fell without an accept")
  // no final output word straight out of reset, whatever cfg and input show
  `ASSERT_IMPL(a_first_out, clk_i, rst_ni, !$past(rst_ni) && cfg_seen, !m_axis_tlast_o || !m_axis_tvalid_o, "output word right after reset")

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
